// ----- src/ssts_pkg.sv -----
package ssts_pkg;

   localparam int MAX_ROWS  = 1024;
   localparam int FRAC_BITS = 16;
   localparam int ADDR_W    = $clog2(MAX_ROWS);
   localparam int DATA_W    = 32;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(NUM_W + 1);
   localparam int QUEUE_D   = 2;

   localparam logic [1:0] MODE_RHS    = 2'd0;
   localparam logic [1:0] MODE_OFF    = 2'd1;
   localparam logic [1:0] MODE_DIAG   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [9:0]         row;
      logic [9:0]         col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [9:0]         solved_row;
      logic signed [31:0] solution;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } cmd_type;

endpackage

// ----- src/sparse_lower_triangular_solve.sv -----
// sequencing: a right-hand-side load is written straight from idle; an
// off-diagonal entry reads the column and the row, multiplies, then writes the
// row back; a diagonal entry reads the row, runs the 48-step divider (skipped
// for a zero diagonal) and waits for the result register to be free
// each item is finished before the next one leaves the queue
// reset: synchronous, clears queues, sequencer and saturation flag; the
// solution memory is not cleared
module sparse_lower_triangular_solve (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ssts_pkg::req_type req_item,
   output logic              empty,
   input  logic              pop,
   output ssts_pkg::rsp_type rsp_item
);
   import ssts_pkg::*;

   // command from the front queue to the back sequencer
   cmd_type cmd;
   logic    cmd_pop;

   // front: takes items, drops unused modes, buffers two commands
   ssts_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_item(req_item),
      .cmd     (cmd),
      .cmd_pop (cmd_pop)
   );

   // back: memory read-modify-write, multiply, divide, result register
   ssts_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .cmd_pop (cmd_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp_item(rsp_item)
   );
endmodule

// ----- src/ssts_ram.sv -----
module ssts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ----- src/ssts_front.sv -----
module ssts_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ssts_pkg::req_type req_item,
   output ssts_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import ssts_pkg::*;

   req_type    q_ff [QUEUE_D];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       keep, enq, deq;

   // drop unused mode and out-of-range indexes
   always_comb begin
      keep = (req_item.mode != MODE_UNUSED) && (32'(req_item.row) < MAX_ROWS);
      if (req_item.mode == MODE_OFF && 32'(req_item.col) >= MAX_ROWS) begin
         keep = 1'b0;
      end
   end

   assign full = (cnt_ff == 2'(QUEUE_D));
   assign enq  = push && !full && keep;
   assign deq  = cmd_pop && (cnt_ff != 2'd0);

   assign wp_in  = enq ? ~wp_ff : wp_ff;
   assign rp_in  = deq ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, enq} - {1'b0, deq};

   assign cmd.valid = (cnt_ff != 2'd0);
   assign cmd.item  = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (enq) begin
         q_ff[wp_ff] <= req_item;
      end
   end
endmodule

// ----- src/ssts_back.sv -----
module ssts_back (
   input  logic              clock,
   input  logic              reset,
   input  ssts_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output ssts_pkg::rsp_type rsp_item
);
   import ssts_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_RD_COL = 7'b0000010,
      S_RD_ROW = 7'b0000100,
      S_MUL    = 7'b0001000,
      S_ACC    = 7'b0010000,
      S_DIV    = 7'b0100000,
      S_FIN    = 7'b1000000
   } state_type;

   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [NUM_W-1:0] MAG_MAX = NUM_W'(64'h7FFF_FFFF);
   localparam logic [NUM_W-1:0] MAG_MIN = NUM_W'(64'h8000_0000);

   state_type state_ff, state_in;
   req_type   cmd_ff, cmd_in;
   logic signed [DATA_W-1:0]   xcol_ff, xcol_in, cur_ff, cur_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DATA_W-1:0]  dmag_ff, dmag_in;
   logic               neg_ff, neg_in, zero_ff, zero_in, sat_ff, sat_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic                     wr_en, rd_en;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;
   logic [DATA_W-1:0]        wr_data, rd_data;
   logic signed [2*DATA_W:0] acc;
   logic signed [NUM_W-1:0]  num;
   logic [DATA_W:0]          rem_sh;
   logic signed [DATA_W-1:0] fin_val;
   logic                     fin_sat;

   ssts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_ff;

   always_comb begin
      acc    = (2*DATA_W+1)'(cur_ff) - (2*DATA_W+1)'(prod_ff >>> FRAC_BITS);
      num    = NUM_W'($signed(rd_data)) <<< FRAC_BITS;
      rem_sh = {rem_ff[DATA_W-1:0], quo_ff[NUM_W-1]};
      // final quotient with sign and clamp
      fin_sat = 1'b0;
      if (neg_ff) begin
         if (quo_ff > MAG_MIN) begin
            fin_val = Q_MIN;
            fin_sat = 1'b1;
         end else begin
            fin_val = DATA_W'(-quo_ff);
         end
      end else begin
         if (quo_ff > MAG_MAX) begin
            fin_val = Q_MAX;
            fin_sat = 1'b1;
         end else begin
            fin_val = DATA_W'(quo_ff);
         end
      end
      if (zero_ff) begin
         fin_val = cur_ff[DATA_W-1] ? Q_MIN : Q_MAX;
         fin_sat = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      xcol_in  = xcol_ff;
      cur_in   = cur_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dmag_in  = dmag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      sat_in   = sat_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      cmd_pop  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = cmd_ff.row[ADDR_W-1:0];
      wr_data  = cur_ff;
      rd_en    = 1'b0;
      rd_addr  = cmd.item.row[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (cmd.valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd.item;
               case (cmd.item.mode)
                  MODE_RHS: begin
                     wr_en   = 1'b1;
                     wr_addr = cmd.item.row[ADDR_W-1:0];
                     wr_data = cmd.item.value;
                  end
                  MODE_OFF: begin
                     rd_en    = 1'b1;
                     rd_addr  = cmd.item.col[ADDR_W-1:0];
                     state_in = S_RD_COL;
                  end
                  default: begin
                     rd_en    = 1'b1;
                     state_in = S_RD_ROW;
                  end
               endcase
            end
         end
         S_RD_COL: begin
            xcol_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = cmd_ff.row[ADDR_W-1:0];
            state_in = S_RD_ROW;
         end
         S_RD_ROW: begin
            cur_in = rd_data;
            if (cmd_ff.mode == MODE_OFF) begin
               state_in = S_MUL;
            end else begin
               zero_in = (cmd_ff.value == '0);
               neg_in  = num[NUM_W-1] ^ cmd_ff.value[DATA_W-1];
               quo_in  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
               dmag_in = cmd_ff.value[DATA_W-1] ? DATA_W'(-cmd_ff.value)
                                                : DATA_W'(cmd_ff.value);
               rem_in  = '0;
               cnt_in  = CNT_W'(NUM_W);
               state_in = (cmd_ff.value == '0) ? S_FIN : S_DIV;
            end
         end
         S_MUL: begin
            prod_in  = cmd_ff.value * xcol_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            wr_en = 1'b1;
            if (acc > (2*DATA_W+1)'(Q_MAX)) begin
               wr_data = Q_MAX;
               sat_in  = 1'b1;
            end else if (acc < (2*DATA_W+1)'(Q_MIN)) begin
               wr_data = Q_MIN;
               sat_in  = 1'b1;
            end else begin
               wr_data = DATA_W'(acc);
            end
            state_in = S_IDLE;
         end
         S_DIV: begin
            // one quotient bit per cycle, restoring
            if (rem_sh >= {1'b0, dmag_ff}) begin
               rem_in = rem_sh - {1'b0, dmag_ff};
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || pop) begin
               wr_en   = 1'b1;
               wr_data = fin_val;
               rsp_in.solved_row = cmd_ff.row;
               rsp_in.solution   = fin_val;
               rsp_in.status     = zero_ff ? ST_ZERO :
                                   ((sat_ff || fin_sat) ? ST_SAT : ST_OK);
               rsp_valid_in = 1'b1;
               sat_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      xcol_ff <= xcol_in;
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end
endmodule

// ----- verif/ssts_checker.sv -----
module ssts_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  ssts_pkg::req_type req_item,
   input  logic              empty,
   input  logic              pop,
   input  ssts_pkg::rsp_type rsp_item,
   output int                errors,
   output int                pending,
   output int                n_results,
   output int                n_zero,
   output int                n_sat
);
   timeunit 1ns;
   timeprecision 1ps;
   import ssts_pkg::*;

   localparam longint Q_HI = 64'sd2147483647;
   localparam longint Q_LO = -64'sd2147483648;

   logic signed [31:0] x_mem [MAX_ROWS];
   logic               sat_seen;
   rsp_type            solved_q [$];

   initial begin
      errors    = 0;
      n_results = 0;
      n_zero    = 0;
      n_sat     = 0;
      sat_seen  = 1'b0;
   end

   assign pending = solved_q.size();

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic signed [31:0] clamp(input longint v);
      if (v > Q_HI) begin
         sat_seen = 1'b1;
         return Q_HI[31:0];
      end
      if (v < Q_LO) begin
         sat_seen = 1'b1;
         return Q_LO[31:0];
      end
      return v[31:0];
   endfunction

   // forward substitution step, queues a solved value on a diagonal item
   function automatic void substitute(input req_type it);
      longint  acc;
      longint  prod;
      rsp_type r;
      if (it.mode == MODE_RHS) begin
         x_mem[it.row] = it.value;
      end else if (it.mode == MODE_OFF) begin
         prod = longint'(it.value) * longint'(x_mem[it.col]);
         acc  = longint'(x_mem[it.row]) - (prod >>> FRAC_BITS);
         x_mem[it.row] = clamp(acc);
      end else if (it.mode == MODE_DIAG) begin
         acc = longint'(x_mem[it.row]);
         if (it.value == 0) begin
            x_mem[it.row] = (acc >= 0) ? Q_HI[31:0] : Q_LO[31:0];
            r.status = ST_ZERO;
         end else begin
            x_mem[it.row] = clamp((acc <<< FRAC_BITS) / longint'(it.value));
            r.status = sat_seen ? ST_SAT : ST_OK;
         end
         sat_seen     = 1'b0;
         r.solved_row = it.row;
         r.solution   = x_mem[it.row];
         solved_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         solved_q.delete();
         sat_seen = 1'b0;
      end else begin
         if (pop && !empty) begin
            if (solved_q.size() == 0) begin
               report($sformatf("unexpected result row %0d", rsp_item.solved_row));
            end else begin
               if (rsp_item.solved_row !== solved_q[0].solved_row)
                  report($sformatf("solved_row got %0d want %0d",
                                   rsp_item.solved_row, solved_q[0].solved_row));
               if (rsp_item.solution !== solved_q[0].solution)
                  report($sformatf("row %0d solution got %h want %h",
                                   solved_q[0].solved_row, rsp_item.solution,
                                   solved_q[0].solution));
               if (rsp_item.status !== solved_q[0].status)
                  report($sformatf("row %0d status got %0d want %0d",
                                   solved_q[0].solved_row, rsp_item.status,
                                   solved_q[0].status));
               if (solved_q[0].status == ST_ZERO) n_zero++;
               if (solved_q[0].status == ST_SAT) n_sat++;
               n_results++;
               void'(solved_q.pop_front());
            end
         end
         if (push && !full)
            substitute(req_item);
      end
   end

endmodule

// ----- verif/sparse_lower_triangular_solve_tb.sv -----
module sparse_lower_triangular_solve_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssts_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_LEN   = 400;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_item;
   logic    empty;
   logic    pop;
   rsp_type rsp_item;

   int errors, pending, n_results, n_zero, n_sat;

   // stimulus bookkeeping: rows already holding a value, so no read hits an
   // entry that was never written
   bit written [MAX_ROWS];
   int written_rows [$];
   int n_items;
   int burst_left;
   int hold_req;
   int idle_cycles;

   sparse_lower_triangular_solve u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   ssts_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .errors    (errors),
      .pending   (pending),
      .n_results (n_results),
      .n_zero    (n_zero),
      .n_sat     (n_sat)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // receiver: stall pattern changes phase by phase, plus a long hold-off on request
   initial begin : receiver
      int phase_cnt;
      int style;
      int hold_cnt;
      phase_cnt = 0;
      style     = 0;
      hold_cnt  = 0;
      pop       = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
         end
         if (phase_cnt == 0) begin
            style     = $urandom_range(0, 3);
            phase_cnt = 64;
         end
         phase_cnt--;
         if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
         end else begin
            case (style)
               0: pop <= 1'b1;                          // no stalls
               1: pop <= phase_cnt[0];                  // alternating pop and stall
               2: pop <= ($urandom_range(0, 9) < 3);    // mostly stalled
               default: pop <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   // watchdog: cycles in which neither side moves an item
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d results pending",
                  idle_cycles, pending);
         $display("sparse_lower_triangular_solve verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one item and wait for it to be taken; sender idles between bursts
   task automatic send(input req_type it);
      if (burst_left == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      push     <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (full);
      if (it.mode != MODE_UNUSED) begin
         n_items++;
         if (!written[it.row]) begin
            written[it.row] = 1'b1;
            written_rows.push_back(it.row);
         end
      end
   endtask

   function automatic req_type make_item(input logic [1:0] mode, input int row,
                                         input int col, input logic [31:0] value);
      req_type it;
      it.mode  = mode;
      it.row   = row[9:0];
      it.col   = col[9:0];
      it.value = value;
      return it;
   endfunction

   // operand mix: small fixed-point values dominate, with full-range and extremes
   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      if (sel < 80) return $urandom;
      if (sel < 85) return 32'h7FFF_FFFF;
      if (sel < 90) return 32'h8000_0000;
      if (sel < 95) return 32'hFFFF_FFFF;
      return 32'h0;
   endfunction

   function automatic logic [31:0] pick_diag();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 8) return 32'h0;
      if (sel < 15) return $urandom;
      if (sel < 20) return 32'hFFFF_FFFF;
      // magnitude between 1/4 and 8 in Q16.16, either sign
      if ($urandom_range(0, 1))
         return 32'($urandom_range(32'h4000, 32'h8_0000));
      return -32'($urandom_range(32'h4000, 32'h8_0000));
   endfunction

   function automatic int any_written();
      return written_rows[$urandom_range(0, written_rows.size() - 1)];
   endfunction

   initial begin : stimulus
      int r;
      int nnz;
      int sel;
      push       = 1'b0;
      req_item   = '0;
      reset      = 1'b1;
      n_items    = 0;
      burst_left = 0;
      hold_req   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and each special case
      send(make_item(MODE_RHS, 0, 0, 32'h7FFF_FFFF));
      send(make_item(MODE_RHS, 1023, 1023, 32'h8000_0000));
      send(make_item(MODE_RHS, 5, 0, 32'h0001_0000));
      // huge entry times huge x saturates the row
      send(make_item(MODE_OFF, 5, 0, 32'h7FFF_FFFF));
      send(make_item(MODE_DIAG, 5, 0, 32'h0001_0000));
      // column not below row
      send(make_item(MODE_OFF, 0, 1023, 32'hFFFF_FFFF));
      // zero diagonal on a positive and on a negative value
      send(make_item(MODE_RHS, 3, 0, 32'h0002_0000));
      send(make_item(MODE_DIAG, 3, 0, 32'h0));
      send(make_item(MODE_RHS, 7, 0, 32'hFFFF_0000));
      send(make_item(MODE_DIAG, 7, 0, 32'h0));
      // quotient overflow in the divide
      send(make_item(MODE_RHS, 9, 0, 32'h8000_0000));
      send(make_item(MODE_DIAG, 9, 0, 32'hFFFF_FFFF));
      // unused mode is dropped
      send(make_item(MODE_UNUSED, 1023, 1023, 32'hFFFF_FFFF));
      send(make_item(MODE_UNUSED, 512, 0, 32'h0));
      // ordinary row with two off-diagonal terms
      send(make_item(MODE_RHS, 512, 0, 32'h0003_0000));
      send(make_item(MODE_OFF, 512, 5, 32'h0000_8000));
      send(make_item(MODE_OFF, 512, 3, 32'hFFFF_C000));
      send(make_item(MODE_DIAG, 512, 0, 32'h0002_0000));
      send(make_item(MODE_DIAG, 1023, 0, 32'h8000_0000));
      send(make_item(MODE_DIAG, 0, 0, 32'h7FFF_FFFF));

      // receiver holds off while the sender keeps offering, so the block fills
      hold_req = HOLD_LEN;

      while (n_items < 400) begin
         sel = $urandom_range(0, 99);
         if (sel < 85) begin
            // well-formed row: load, off-diagonal terms on written columns, diagonal
            r = $urandom_range(0, MAX_ROWS - 1);
            if (!written[r] || $urandom_range(0, 9) != 0)
               send(make_item(MODE_RHS, r, $urandom_range(0, 1023), pick_value()));
            nnz = $urandom_range(0, 4);
            repeat (nnz)
               send(make_item(MODE_OFF, r, any_written(), pick_value()));
            send(make_item(MODE_DIAG, r, $urandom_range(0, 1023), pick_diag()));
         end else if (sel < 90) begin
            send(make_item(MODE_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom));
         end else if (sel < 95) begin
            // stray load, no row closed
            send(make_item(MODE_RHS, $urandom_range(0, 1023), $urandom_range(0, 1023),
                           pick_value()));
         end else begin
            // stray term on a row left open
            send(make_item(MODE_OFF, any_written(), any_written(), pick_value()));
         end
      end
      push <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d items, %0d rows solved (%0d zero diagonal, %0d saturated)",
               n_items, n_results, n_zero, n_sat);
      $display("stalls: bursty sender, patterned receiver, one %0d-cycle hold-off",
               HOLD_LEN);
      if (errors == 0) begin
         $display("sparse_lower_triangular_solve verification clean");
      end else begin
         $display("sparse_lower_triangular_solve verification failed");
      end
      $finish;
   end

endmodule
